FILE: hw/rtl/ptst_pkg.sv
// Shared types and constants for the periodic timer slot table.
// No dependencies; every other file of the block but ptst_ram imports this package.
package ptst_pkg;

    localparam int SLOT_COUNT = 32;
    localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int ACTION_W = 2;
    localparam int HANDLE_W = 16;
    localparam int PERIOD_W = 32;
    localparam int COUNT_W  = 33;
    localparam int TOTAL_W  = 64;
    localparam int SLOT_W   = 5;
    localparam int USECS_W  = 32;

    localparam logic [USECS_W-1:0] USECS_RESET = 32'd30000000;

    typedef enum logic [ACTION_W-1:0] {
        ACT_TICK   = 2'd0,
        ACT_ADD    = 2'd1,
        ACT_REMOVE = 2'd2
    } action_t;

    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [PERIOD_W-1:0] period;
        logic [COUNT_W-1:0]  count;
        logic [TOTAL_W-1:0]  total;
    } slot_entry_t;

    localparam int ENTRY_W = $bits(slot_entry_t);

    // controller -> datapath
    typedef struct packed {
        logic             start;
        logic             issue;
        logic [IDX_W-1:0] scan_idx;
        logic             flush;
    } ctrl_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic adv;
        logic busy;
        logic pend_valid;
        logic out_free;
    } dp_status_t;

endpackage

FILE: hw/rtl/ptst_if.sv
// Channel interfaces of the periodic timer slot table: input item, fired
// result and configuration write. Depends on ptst_pkg.
interface ptst_item_if;
    import ptst_pkg::*;
    logic                valid;
    logic                ready;
    logic [ACTION_W-1:0] action;
    logic [HANDLE_W-1:0] handle;
    logic [PERIOD_W-1:0] period_us;

    modport source (output valid, action, handle, period_us, input ready);
    modport sink   (input valid, action, handle, period_us, output ready);
endinterface

interface ptst_fired_if;
    import ptst_pkg::*;
    logic                valid;
    logic                ready;
    logic [HANDLE_W-1:0] fired_handle;
    logic [SLOT_W-1:0]   fired_slot;
    logic [TOTAL_W-1:0]  total_elapsed_us;
    logic                last;

    modport source (output valid, fired_handle, fired_slot, total_elapsed_us, last,
                    input ready);
    modport sink   (input valid, fired_handle, fired_slot, total_elapsed_us, last,
                    output ready);
endinterface

interface ptst_cfg_if;
    import ptst_pkg::*;
    logic               valid;
    logic               ready;
    logic [USECS_W-1:0] tick_step_us;

    modport source (output valid, tick_step_us, input ready);
    modport sink   (input valid, tick_step_us, output ready);
endinterface

FILE: hw/rtl/ptst_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ptst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: hw/rtl/ptst_ctrl.sv
// Sequencer of the periodic timer slot table: walks the slot index once per
// item, then drains the datapath pipeline and flushes the held result. Uses ptst_pkg.
module ptst_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_accept,
    input  ptst_pkg::dp_status_t  status,
    output logic                  in_ready,
    output ptst_pkg::ctrl_cmd_t   cmd
);
    import ptst_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_SCAN  = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_FLUSH = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

    state_t           state_reg, state_next;
    logic [IDX_W-1:0] idx_reg, idx_next;

    always_comb
    begin
        state_next   = state_reg;
        idx_next     = idx_reg;
        cmd          = '0;
        cmd.scan_idx = idx_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                begin
                    cmd.start  = 1'b1;
                    idx_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                cmd.issue = 1'b1;
                if (status.adv)
                begin
                    if (idx_reg == LAST_IDX)
                    begin
                        state_next = ST_DRAIN;
                    end
                    else
                    begin
                        idx_next = idx_reg + 1'b1;
                    end
                end
            end
            ST_DRAIN:
            begin
                if (!status.busy)
                begin
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                cmd.flush = 1'b1;
                if (!status.pend_valid || status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign in_ready = (state_reg == ST_IDLE);

endmodule

FILE: hw/rtl/ptst_dp.sv
// Datapath of the periodic timer slot table: slot RAM, occupancy flags,
// three-stage scan pipeline and the result registers. Uses ptst_pkg, ptst_ram.
module ptst_dp (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    input  logic [ptst_pkg::USECS_W-1:0]   cfg_usecs,
    input  logic                           in_accept,
    input  logic [ptst_pkg::ACTION_W-1:0]  in_action,
    input  logic [ptst_pkg::HANDLE_W-1:0]  in_handle,
    input  logic [ptst_pkg::PERIOD_W-1:0]  in_period,
    input  ptst_pkg::ctrl_cmd_t            cmd,
    output ptst_pkg::dp_status_t           status,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic [ptst_pkg::HANDLE_W-1:0]  out_handle,
    output logic [ptst_pkg::SLOT_W-1:0]    out_slot,
    output logic [ptst_pkg::TOTAL_W-1:0]   out_total,
    output logic                           out_last
);
    import ptst_pkg::*;

    // config and latched item
    logic [USECS_W-1:0]  usecs_reg;
    logic [ACTION_W-1:0] action_reg;
    logic [HANDLE_W-1:0] handle_reg;
    logic [PERIOD_W-1:0] period_reg;

    // scan bookkeeping
    logic                  found_reg;
    logic [SLOT_COUNT-1:0] occ_reg;

    // pipeline stages
    logic             s1_v_reg, s1_occ_reg;
    logic [IDX_W-1:0] s1_idx_reg;
    logic             s2_v_reg, s2_occ_reg;
    logic [IDX_W-1:0] s2_idx_reg;
    slot_entry_t      s2_entry_reg, s2_entry_next;

    // held result and output register
    logic                pend_v_reg;
    logic [HANDLE_W-1:0] pend_handle_reg;
    logic [SLOT_W-1:0]   pend_slot_reg;
    logic [TOTAL_W-1:0]  pend_total_reg;
    logic                out_v_reg;
    logic [HANDLE_W-1:0] out_handle_reg;
    logic [SLOT_W-1:0]   out_slot_reg;
    logic [TOTAL_W-1:0]  out_total_reg;
    logic                out_last_reg;

    logic        is_tick, is_add, is_remove;
    logic        out_free, adv;
    logic        add_hit, rm_hit;
    logic        act2, fire, fire_go, push_mid, push_end;
    logic        ram_we, ram_re;
    logic [IDX_W-1:0] ram_waddr;
    slot_entry_t ram_wdata, ram_rdata;
    slot_entry_t add_entry, tick_entry;
    logic [TOTAL_W-1:0] new_total;

    assign is_tick   = (action_reg == ACT_TICK);
    assign is_add    = (action_reg == ACT_ADD);
    assign is_remove = (action_reg == ACT_REMOVE);

    // the pipeline moves unless a new expiry could find both result slots full
    assign out_free = !out_v_reg || out_ready;
    assign adv      = !pend_v_reg || out_free;

    // stage 0: address issue; adds are decided on the occupancy flags alone
    assign ram_re  = cmd.issue && adv;
    assign add_hit = ram_re && is_add && !found_reg && !occ_reg[cmd.scan_idx]
                     && (handle_reg != '0) && (period_reg != '0);

    // stage 1: RAM data back; first matching occupied slot is removed
    assign rm_hit = s1_v_reg && adv && s1_occ_reg && is_remove && !found_reg
                    && (ram_rdata.handle == handle_reg);

    // stage 2: expiry check and write-back
    assign act2      = s2_v_reg && s2_occ_reg && is_tick;
    assign fire      = act2 && (s2_entry_reg.count >= COUNT_W'(s2_entry_reg.period));
    assign new_total = s2_entry_reg.total + TOTAL_W'(s2_entry_reg.count);
    assign fire_go   = fire && adv;
    assign push_mid  = fire_go && pend_v_reg;
    assign push_end  = cmd.flush && pend_v_reg && out_free;

    // stage 1 -> 2: count advanced by one tick step
    always_comb
    begin
        s2_entry_next       = ram_rdata;
        s2_entry_next.count = ram_rdata.count + COUNT_W'(usecs_reg);
    end

    always_comb
    begin
        add_entry        = '0;
        add_entry.handle = handle_reg;
        add_entry.period = period_reg;

        tick_entry       = s2_entry_reg;
        if (fire)
        begin
            tick_entry.count = '0;
            tick_entry.total = new_total;
        end

        if (add_hit)
        begin
            ram_we    = 1'b1;
            ram_waddr = cmd.scan_idx;
            ram_wdata = add_entry;
        end
        else
        begin
            ram_we    = act2 && adv;
            ram_waddr = s2_idx_reg;
            ram_wdata = tick_entry;
        end
    end

    ptst_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOT_COUNT)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (cmd.scan_idx),
        .rdata (ram_rdata)
    );

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            usecs_reg  <= USECS_RESET;
            found_reg  <= 1'b0;
            occ_reg    <= '0;
            s1_v_reg   <= 1'b0;
            s2_v_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                usecs_reg <= cfg_usecs;
            end

            if (cmd.start)
            begin
                found_reg <= 1'b0;
            end
            else if (add_hit || rm_hit)
            begin
                found_reg <= 1'b1;
            end

            if (add_hit)
            begin
                occ_reg[cmd.scan_idx] <= 1'b1;
            end
            if (rm_hit)
            begin
                occ_reg[s1_idx_reg] <= 1'b0;
            end

            if (adv)
            begin
                s1_v_reg <= cmd.issue;
                s2_v_reg <= s1_v_reg;
            end

            if (fire_go)
            begin
                pend_v_reg <= 1'b1;
            end
            else if (push_end)
            begin
                pend_v_reg <= 1'b0;
            end

            if (push_mid || push_end)
            begin
                out_v_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_v_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            action_reg <= in_action;
            handle_reg <= in_handle;
            period_reg <= in_period;
        end

        if (adv)
        begin
            s1_idx_reg   <= cmd.scan_idx;
            s1_occ_reg   <= occ_reg[cmd.scan_idx];
            s2_idx_reg   <= s1_idx_reg;
            s2_occ_reg   <= s1_occ_reg;
            s2_entry_reg <= s2_entry_next;
        end

        if (fire_go)
        begin
            pend_handle_reg <= s2_entry_reg.handle;
            pend_slot_reg   <= SLOT_W'(s2_idx_reg);
            pend_total_reg  <= new_total;
        end

        if (push_mid || push_end)
        begin
            out_handle_reg <= pend_handle_reg;
            out_slot_reg   <= pend_slot_reg;
            out_total_reg  <= pend_total_reg;
            out_last_reg   <= push_end;
        end
    end

    assign status.adv        = adv;
    assign status.busy       = s1_v_reg || s2_v_reg;
    assign status.pend_valid = pend_v_reg;
    assign status.out_free   = out_free;

    assign out_valid  = out_v_reg;
    assign out_handle = out_handle_reg;
    assign out_slot   = out_slot_reg;
    assign out_total  = out_total_reg;
    assign out_last   = out_last_reg;

endmodule

FILE: hw/rtl/periodic_timer_slot_table.sv
// Top level of the periodic timer slot table: channel ports, sequencer and
// datapath. Uses ptst_pkg, ptst_if, ptst_ctrl, ptst_dp.
//
// Usage:
//   item_in : action (0 tick, 1 add, 2 remove), handle, period_us. An item is
//             taken when valid and ready are both high; ready is high only
//             while the block is idle.
//   fired   : one item per slot that expires on a tick, in slot order, with
//             last set on the final one of that tick. Add and remove give none.
//   cfg     : writes tick_step_us; always ready, write only while idle.
// Scan: every item walks all 32 slots, one slot RAM read per cycle while the
//   scan is not stalled (see Stall), through a three-stage read / add /
//   compare-and-write-back pipeline. An item passes accept, scan, drain and
//   flush in that order before ready is high again.
// The newest expiry is held back one place so that last can be set on it;
//   fired items therefore leave one expiry behind the scan, the final one in
//   the flush cycle.
// Stall: if fired holds an unaccepted item and another one is held back,
//   the scan freezes until fired is taken; nothing is dropped.
// Reset: all slot occupancy flags clear at once (no RAM clearing pass),
//   tick_step_us returns to 30000000, fired goes invalid.
module periodic_timer_slot_table (
    input  logic         clk,
    input  logic         rst_n,
    ptst_cfg_if.sink     cfg,
    ptst_item_if.sink    item_in,
    ptst_fired_if.source fired
);
    import ptst_pkg::*;

    ctrl_cmd_t  cmd;
    dp_status_t status;
    logic       in_ready;
    logic       in_accept;

    assign in_accept     = item_in.valid && in_ready;
    assign item_in.ready = in_ready;

    // register file is a single register, writable any cycle
    assign cfg.ready = 1'b1;

    ptst_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_accept (in_accept),
        .status    (status),
        .in_ready  (in_ready),
        .cmd       (cmd)
    );

    ptst_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg.valid),
        .cfg_usecs  (cfg.tick_step_us),
        .in_accept  (in_accept),
        .in_action  (item_in.action),
        .in_handle  (item_in.handle),
        .in_period  (item_in.period_us),
        .cmd        (cmd),
        .status     (status),
        .out_ready  (fired.ready),
        .out_valid  (fired.valid),
        .out_handle (fired.fired_handle),
        .out_slot   (fired.fired_slot),
        .out_total  (fired.total_elapsed_us),
        .out_last   (fired.last)
    );

endmodule

FILE: hw/rtl/ptst_checker.sv
// Port-level checks for the periodic timer slot table, bound to the top level.
// Uses ptst_pkg; attaches to periodic_timer_slot_table.
module ptst_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          item_valid,
    input logic                          item_ready,
    input logic                          fired_valid,
    input logic                          fired_ready,
    input logic [ptst_pkg::HANDLE_W-1:0] fired_handle,
    input logic [ptst_pkg::SLOT_W-1:0]   fired_slot,
    input logic [ptst_pkg::TOTAL_W-1:0]  fired_total,
    input logic                          fired_last
);
    import ptst_pkg::*;

    // an accepted item keeps item ready low at the start of the scan
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready ##1 !item_ready
    ) else $error("item ready returned too early after accept");

    // fired items are only produced while an item is in work
    a_fire_only_when_busy: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(fired_valid) |-> !$past(item_ready)
    ) else $error("fired item appeared while idle");

    // leaving reset: idle and nothing to deliver
    a_reset_state: assert property (
        @(posedge clk)
        $rose(rst_n) |-> item_ready && !fired_valid
    ) else $error("block not idle after reset");

    a_fired_hold: assert property (
        @(posedge clk) disable iff (!rst_n)
        fired_valid && !fired_ready |=> fired_valid
            && $stable(fired_handle) && $stable(fired_slot)
            && $stable(fired_total) && $stable(fired_last)
    ) else $error("stalled fired item changed");

endmodule

bind periodic_timer_slot_table ptst_checker u_ptst_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_in.valid),
    .item_ready   (item_in.ready),
    .fired_valid  (fired.valid),
    .fired_ready  (fired.ready),
    .fired_handle (fired.fired_handle),
    .fired_slot   (fired.fired_slot),
    .fired_total  (fired.total_elapsed_us),
    .fired_last   (fired.last)
);
